/* hw/rtl/silt_pkg.sv */
// silt_pkg: shared constants, codes and control/status types for the sorted list table
// used by silt_ctrl, silt_dp and sorted_insert_list_table_top; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package silt_pkg;

  localparam int LIST_DEPTH_DEF = 16;
  localparam int NUM_LISTS_DEF  = 3;

  localparam int FUNC_W    = 2;
  localparam int SEL_W     = 2;
  localparam int ID_W      = 16;
  localparam int POS_W     = 10;
  localparam int CNT_OUT_W = 5;

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_DELETE = 2'd1,
    FN_QUERY  = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_RD,
    ST_CHK,
    ST_PUT,
    ST_FIN
  } state_t;

  // datapath -> controller
  typedef struct packed {
    logic list_ok;
    logic is_ins;
    logic is_del;
    logic cnt_zero;
    logic full;
    logic pos_ge;
    logic id_hit;
    logic found;
    logic last;
    logic idx_one;
    logic out_busy;
  } silt_sts_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic idx_from_cnt;
    logic idx_clear;
    logic ins_shift;
    logic put_new;
    logic del_step;
    logic cnt_dec;
    logic out_load;
  } silt_cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/silt_ctrl.sv */
// silt_ctrl: sequencer for insert, delete and query transactions
// depends on silt_pkg (state, command and status types)
`timescale 1ns / 1ps
`default_nettype none

module silt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire silt_pkg::silt_sts_t sts,
  output silt_pkg::silt_cmd_t     cmd
);

  silt_pkg::state_t state_r;
  silt_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= silt_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != silt_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      silt_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = silt_pkg::ST_START;
        end
      end
      silt_pkg::ST_START: begin
        if (!sts.list_ok || !(sts.is_ins || sts.is_del)) begin
          state_nxt = silt_pkg::ST_FIN;
        end else if (sts.is_ins) begin
          if (sts.full) begin
            state_nxt = silt_pkg::ST_FIN;
          end else begin
            cmd.idx_from_cnt = 1'b1;
            state_nxt = sts.cnt_zero ? silt_pkg::ST_PUT : silt_pkg::ST_RD;
          end
        end else begin
          if (sts.cnt_zero) begin
            state_nxt = silt_pkg::ST_FIN;
          end else begin
            cmd.idx_clear = 1'b1;
            state_nxt     = silt_pkg::ST_RD;
          end
        end
      end
      silt_pkg::ST_RD: begin
        state_nxt = silt_pkg::ST_CHK;
      end
      silt_pkg::ST_CHK: begin
        if (sts.is_ins) begin
          // walk down from the top, moving entries up until the slot is found
          if (sts.pos_ge) begin
            cmd.ins_shift = 1'b1;
            state_nxt = sts.idx_one ? silt_pkg::ST_PUT : silt_pkg::ST_RD;
          end else begin
            state_nxt = silt_pkg::ST_PUT;
          end
        end else begin
          cmd.del_step = 1'b1;
          if (sts.last) begin
            cmd.cnt_dec = sts.found || sts.id_hit;
            state_nxt   = silt_pkg::ST_FIN;
          end else begin
            state_nxt = silt_pkg::ST_RD;
          end
        end
      end
      silt_pkg::ST_PUT: begin
        cmd.put_new = 1'b1;
        state_nxt   = silt_pkg::ST_FIN;
      end
      silt_pkg::ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = silt_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = silt_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/silt_dp.sv */
// silt_dp: entry memory, per-list counts, walk index and result register
// depends on silt_pkg (field widths, codes, command and status types)
`timescale 1ns / 1ps
`default_nettype none

module silt_dp #(
  parameter int LIST_DEPTH = silt_pkg::LIST_DEPTH_DEF,
  parameter int NUM_LISTS  = silt_pkg::NUM_LISTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [silt_pkg::FUNC_W-1:0]    in_func,
  input  wire logic [silt_pkg::SEL_W-1:0]     in_list_sel,
  input  wire logic [silt_pkg::ID_W-1:0]      in_item_id,
  input  wire logic [silt_pkg::POS_W-1:0]     in_position,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_ok,
  output logic                                out_list_empty,
  output logic [silt_pkg::CNT_OUT_W-1:0]      out_list_count,
  input  wire silt_pkg::silt_cmd_t            cmd,
  output silt_pkg::silt_sts_t                 sts
);

  localparam int SW        = $clog2(LIST_DEPTH);
  localparam int CW        = $clog2(LIST_DEPTH + 1);
  localparam int LW        = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
  localparam int AW        = LW + SW;
  localparam int MEM_DEPTH = 1 << AW;
  localparam int EW        = silt_pkg::ID_W + silt_pkg::POS_W;
  localparam logic [3:0]    NUM_LISTS_V = 4'(NUM_LISTS);
  localparam logic [CW-1:0] FULL_CNT    = CW'(LIST_DEPTH);

  logic [silt_pkg::FUNC_W-1:0] func_r;
  logic [silt_pkg::SEL_W-1:0]  sel_r;
  logic [silt_pkg::ID_W-1:0]   id_r;
  logic [silt_pkg::POS_W-1:0]  pos_r;
  logic [SW-1:0]               idx_r;
  logic [SW-1:0]               idx_nxt;
  logic                        ok_r;
  logic [CW-1:0]               counts_r [NUM_LISTS];
  logic [EW-1:0]               mem [MEM_DEPTH];
  logic [EW-1:0]               rdata_r;

  logic                        out_valid_r;
  logic                        out_ok_r;
  logic                        out_empty_r;
  logic [silt_pkg::CNT_OUT_W-1:0] out_count_r;
  logic                        out_ok_nxt;
  logic                        out_empty_nxt;
  logic [silt_pkg::CNT_OUT_W-1:0] out_count_nxt;

  logic [LW+silt_pkg::SEL_W-1:0] sel_ext;
  logic [LW-1:0]               li;
  logic                        list_ok;
  logic [CW-1:0]               cnt_cur;
  logic [CW+silt_pkg::CNT_OUT_W-1:0] cnt_wide;
  logic                        is_ins;
  logic                        is_del;
  logic                        is_query;
  logic [silt_pkg::ID_W-1:0]   rd_id;
  logic [silt_pkg::POS_W-1:0]  rd_pos;
  logic [AW-1:0]               rd_addr;
  logic                        wr_en;
  logic [AW-1:0]               wr_addr;
  logic [EW-1:0]               wr_data;

  // transaction fields
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_r <= in_func;
      sel_r  <= in_list_sel;
      id_r   <= in_item_id;
      pos_r  <= in_position;
    end
  end

  assign sel_ext = {{LW{1'b0}}, sel_r};
  assign li      = sel_ext[LW-1:0];
  assign list_ok = ({2'b00, sel_r} < NUM_LISTS_V);
  assign cnt_cur = list_ok ? counts_r[li] : '0;

  always_comb begin
    is_ins   = 1'b0;
    is_del   = 1'b0;
    is_query = 1'b0;
    unique case (func_r)
      silt_pkg::FN_INSERT: is_ins   = 1'b1;
      silt_pkg::FN_DELETE: is_del   = 1'b1;
      silt_pkg::FN_QUERY:  is_query = 1'b1;
      default: begin
      end
    endcase
  end

  // walk index: slot being filled on insert, slot being read on delete
  always_comb begin
    idx_nxt = idx_r;
    if (cmd.idx_from_cnt) begin
      idx_nxt = cnt_cur[SW-1:0];
    end else if (cmd.idx_clear) begin
      idx_nxt = '0;
    end else if (cmd.ins_shift) begin
      idx_nxt = idx_r - SW'(1);
    end else if (cmd.del_step) begin
      idx_nxt = idx_r + SW'(1);
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ok_r <= 1'b0;
    end else if (cmd.put_new || (cmd.del_step && sts.id_hit)) begin
      ok_r <= 1'b1;
    end
  end

  // entry memory
  assign rd_addr = is_ins ? {li, idx_r - SW'(1)} : {li, idx_r};

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = {li, idx_r};
    wr_data = rdata_r;
    if (cmd.put_new) begin
      wr_en   = 1'b1;
      wr_data = {id_r, pos_r};
    end else if (cmd.ins_shift) begin
      wr_en = 1'b1;
    end else if (cmd.del_step && ok_r) begin
      // pull later entries down over the removed one
      wr_en   = 1'b1;
      wr_addr = {li, idx_r - SW'(1)};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
  end

  assign rd_id  = rdata_r[EW-1:silt_pkg::POS_W];
  assign rd_pos = rdata_r[silt_pkg::POS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        counts_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_LISTS; i++) begin
        if (li == LW'(i)) begin
          if (cmd.put_new) begin
            counts_r[i] <= counts_r[i] + CW'(1);
          end else if (cmd.cnt_dec) begin
            counts_r[i] <= counts_r[i] - CW'(1);
          end
        end
      end
    end
  end

  assign sts.list_ok  = list_ok;
  assign sts.is_ins   = is_ins;
  assign sts.is_del   = is_del;
  assign sts.cnt_zero = (cnt_cur == '0);
  assign sts.full     = (cnt_cur == FULL_CNT);
  assign sts.pos_ge   = (rd_pos >= pos_r);
  assign sts.id_hit   = (rd_id == id_r);
  assign sts.found    = ok_r;
  assign sts.last     = ((CW'(idx_r) + CW'(1)) == cnt_cur);
  assign sts.idx_one  = (idx_r == SW'(1));
  assign sts.out_busy = out_valid_r && out_stall;

  // result register
  assign cnt_wide = {{silt_pkg::CNT_OUT_W{1'b0}}, cnt_cur};

  always_comb begin
    if (!list_ok) begin
      out_ok_nxt    = 1'b0;
      out_empty_nxt = 1'b1;
      out_count_nxt = '0;
    end else begin
      out_empty_nxt = (cnt_cur == '0);
      out_ok_nxt    = is_query ? (cnt_cur == '0) : ok_r;
      out_count_nxt = cnt_wide[silt_pkg::CNT_OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_ok_r    <= out_ok_nxt;
      out_empty_r <= out_empty_nxt;
      out_count_r <= out_count_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_ok         = out_ok_r;
  assign out_list_empty = out_empty_r;
  assign out_list_count = out_count_r;

  // a stored insert raises the selected list's count by one
  a_put_inc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.put_new |=> counts_r[$past(li)] == ($past(cnt_cur) + CW'(1)))
    else $error("insert did not advance list count");

  // a delete only shrinks the list when the id was seen
  a_dec_found: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> (ok_r || sts.id_hit))
    else $error("count decremented without a matching id");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

/* hw/rtl/sorted_insert_list_table_top.sv */
// sorted_insert_list_table_top: NUM_LISTS sorted (id, position) lists with insert/delete/query
// depends on silt_pkg, silt_ctrl and silt_dp
`timescale 1ns / 1ps
`default_nettype none

// One transaction at a time; every transaction returns one result. All lists share one
// entry memory with one read and one write port, walked slot by slot (read, then check and
// move), so the cost depends on list contents. A query, a bad list, an unused code or a
// full/empty failure skips the walk; an insert walks down over the entries with position
// not less than the new one, moving each up, and a delete walks all n entries of the list,
// where n is the list's count. The next transaction can be taken in the cycle after the
// result is loaded, even while that result is still stalled; a result still waiting when
// the next one is ready holds the sequencer until it leaves. No clearing pass after reset:
// the counts reset to zero and slots above a list's count are never read.

module sorted_insert_list_table_top #(
  parameter int LIST_DEPTH = silt_pkg::LIST_DEPTH_DEF,
  parameter int NUM_LISTS  = silt_pkg::NUM_LISTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [silt_pkg::FUNC_W-1:0] in_func,
  input  wire logic [silt_pkg::SEL_W-1:0]  in_list_sel,
  input  wire logic [silt_pkg::ID_W-1:0]   in_item_id,
  input  wire logic [silt_pkg::POS_W-1:0]  in_position,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_ok,
  output logic                             out_list_empty,
  output logic [silt_pkg::CNT_OUT_W-1:0]   out_list_count
);

  silt_pkg::silt_cmd_t cmd;
  silt_pkg::silt_sts_t sts;

  silt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  silt_dp #(
    .LIST_DEPTH (LIST_DEPTH),
    .NUM_LISTS  (NUM_LISTS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_func        (in_func),
    .in_list_sel    (in_list_sel),
    .in_item_id     (in_item_id),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_ok         (out_ok),
    .out_list_empty (out_list_empty),
    .out_list_count (out_list_count),
    .cmd            (cmd),
    .sts            (sts)
  );

endmodule

`default_nettype wire

/* dv/testbench.sv */
// testbench for sorted_insert_list_table_top: directed and random insert/delete/query traffic
// checked against a scoreboard that tracks all lists; depends on silt_pkg and the rtl top
`timescale 1ns / 1ps

typedef struct {
  logic       ok;
  logic       empty;
  logic [4:0] count;
} list_status_t;

class list_table_tracker;
  localparam int DEPTH  = silt_pkg::LIST_DEPTH_DEF;
  localparam int NLISTS = silt_pkg::NUM_LISTS_DEF;

  bit [15:0]    ids   [NLISTS][DEPTH];
  bit [9:0]     keys  [NLISTS][DEPTH];
  int unsigned  counts[NLISTS];
  list_status_t pending_status[$];
  int unsigned  mismatches;
  int unsigned  results_seen;
  int unsigned  full_refusals;
  int unsigned  absent_deletes;

  function new();
    foreach (counts[i]) counts[i] = 0;
    mismatches     = 0;
    results_seen   = 0;
    full_refusals  = 0;
    absent_deletes = 0;
  endfunction

  // apply one accepted transaction to the tracked lists and queue its status
  function void note_input(logic [1:0] func, logic [1:0] sel, logic [15:0] id,
                           logic [9:0] pos);
    list_status_t st;
    int unsigned  n;
    int unsigned  at;
    int unsigned  k;
    st.ok    = 1'b0;
    st.empty = 1'b1;
    st.count = '0;
    if (sel >= NLISTS) begin
      pending_status = {pending_status, st};
      return;
    end
    n = counts[sel];
    case (func)
      silt_pkg::FN_INSERT: begin
        if (n < DEPTH) begin
          at = 0;
          while (at < n && keys[sel][at] < pos) at++;
          for (k = n; k > at; k--) begin
            ids[sel][k]  = ids[sel][k-1];
            keys[sel][k] = keys[sel][k-1];
          end
          ids[sel][at]  = id;
          keys[sel][at] = pos;
          n++;
          st.ok = 1'b1;
        end else begin
          full_refusals++;
        end
      end
      silt_pkg::FN_DELETE: begin
        at = 0;
        while (at < n && ids[sel][at] != id) at++;
        if (at < n) begin
          for (k = at; k + 1 < n; k++) begin
            ids[sel][k]  = ids[sel][k+1];
            keys[sel][k] = keys[sel][k+1];
          end
          n--;
          st.ok = 1'b1;
        end else begin
          absent_deletes++;
        end
      end
      default: ;
    endcase
    counts[sel] = n;
    st.empty = (n == 0);
    st.count = n[4:0];
    if (func == silt_pkg::FN_QUERY) st.ok = (n == 0);
    pending_status = {pending_status, st};
  endfunction

  function void check_result(logic ok, logic empty, logic [4:0] count);
    list_status_t want;
    results_seen++;
    if (pending_status.size() == 0) begin
      $error("result with no transaction outstanding: ok=%0d empty=%0d count=%0d",
             ok, empty, count);
      mismatches++;
      return;
    end
    want = pending_status.pop_front();
    if (ok !== want.ok) begin
      $error("out_ok: expected %0d, actual %0d", want.ok, ok);
      mismatches++;
    end
    if (empty !== want.empty) begin
      $error("out_list_empty: expected %0d, actual %0d", want.empty, empty);
      mismatches++;
    end
    if (count !== want.count) begin
      $error("out_list_count: expected %0d, actual %0d", want.count, count);
      mismatches++;
    end
  endfunction
endclass

module testbench;

  localparam logic [1:0] FN_UNUSED  = 2'd3;
  localparam logic [1:0] BAD_LIST   = 2'd3;
  localparam int         IDLE_LIMIT = 2000;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_func = '0;
  logic [1:0] in_list_sel = '0;
  logic [15:0] in_item_id = '0;
  logic [9:0] in_position = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       out_ok;
  logic       out_list_empty;
  logic [4:0] out_list_count;

  logic        calm = 1'b0;
  int unsigned stall_left = 0;
  int unsigned idle_cycles = 0;

  list_table_tracker tracker = new();

  sorted_insert_list_table_top DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_func       (in_func),
    .in_list_sel   (in_list_sel),
    .in_item_id    (in_item_id),
    .in_position   (in_position),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_ok        (out_ok),
    .out_list_empty(out_list_empty),
    .out_list_count(out_list_count)
  );

  always #5 clk = ~clk;

  // receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 18);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      tracker.check_result(out_ok, out_list_empty, out_list_count);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_op(input logic [1:0] func, input logic [1:0] sel,
                         input logic [15:0] id, input logic [9:0] pos);
    int unsigned gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_func     <= func;
    in_list_sel <= sel;
    in_item_id  <= id;
    in_position <= pos;
    do @(posedge clk); while (in_stall);
    tracker.note_input(func, sel, id, pos);
  endtask

  // random traffic; deletes mostly aim at ids that are really stored
  task automatic run_mix(input int unsigned n, input int unsigned ins_pct,
                         input int unsigned del_pct);
    int unsigned roll;
    logic [1:0]  func;
    logic [1:0]  sel;
    logic [15:0] id;
    logic [9:0]  pos;
    repeat (n) begin
      roll = $urandom_range(0, 99);
      sel  = ($urandom_range(0, 19) == 0) ? BAD_LIST : 2'($urandom_range(0, 2));
      if (roll < ins_pct)                func = silt_pkg::FN_INSERT;
      else if (roll < ins_pct + del_pct) func = silt_pkg::FN_DELETE;
      else if (roll < 97)                func = silt_pkg::FN_QUERY;
      else                               func = FN_UNUSED;
      id = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 15)) : 16'($urandom);
      if (func == silt_pkg::FN_DELETE && sel != BAD_LIST && tracker.counts[sel] != 0 &&
          $urandom_range(0, 4) != 0)
        id = tracker.ids[sel][$urandom_range(0, tracker.counts[sel] - 1)];
      case ($urandom_range(0, 5))
        0:       pos = 10'($urandom_range(0, 7));
        1:       pos = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
        default: pos = 10'($urandom);
      endcase
      send_op(func, sel, id, pos);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list, extremes, ties, duplicates, absent ids, bad selector, unused code
    send_op(silt_pkg::FN_QUERY,  2'd0, 16'h0000, 10'd0);
    send_op(silt_pkg::FN_DELETE, 2'd0, 16'h0005, 10'd0);
    send_op(silt_pkg::FN_INSERT, 2'd0, 16'hFFFF, 10'd1023);
    send_op(silt_pkg::FN_INSERT, 2'd0, 16'h0000, 10'd0);
    send_op(silt_pkg::FN_INSERT, 2'd0, 16'h1234, 10'd512);
    send_op(silt_pkg::FN_INSERT, 2'd0, 16'h5555, 10'd512);
    send_op(silt_pkg::FN_INSERT, 2'd0, 16'h1234, 10'd100);
    send_op(silt_pkg::FN_DELETE, 2'd0, 16'h1234, 10'd0);
    send_op(silt_pkg::FN_DELETE, 2'd0, 16'hABCD, 10'd0);
    send_op(silt_pkg::FN_QUERY,  2'd0, 16'h0000, 10'd0);
    send_op(silt_pkg::FN_INSERT, 2'd1, 16'hAAAA, 10'h2AA);
    send_op(silt_pkg::FN_INSERT, 2'd2, 16'h5555, 10'h155);
    send_op(silt_pkg::FN_QUERY,  BAD_LIST, 16'h0000, 10'd0);
    send_op(silt_pkg::FN_INSERT, BAD_LIST, 16'hFFFF, 10'd1023);
    send_op(silt_pkg::FN_DELETE, BAD_LIST, 16'h5555, 10'd0);
    send_op(FN_UNUSED, 2'd0, 16'hFFFF, 10'd1023);
    send_op(FN_UNUSED, BAD_LIST, 16'h0000, 10'd0);
    send_op(silt_pkg::FN_DELETE, 2'd1, 16'hAAAA, 10'd0);
    send_op(silt_pkg::FN_QUERY,  2'd1, 16'h0000, 10'd0);
    send_op(silt_pkg::FN_DELETE, 2'd0, 16'hFFFF, 10'd0);
    send_op(silt_pkg::FN_DELETE, 2'd0, 16'h1234, 10'd0);

    // push one list past full with random content
    repeat (18) send_op(silt_pkg::FN_INSERT, 2'd2, 16'($urandom), 10'($urandom));

    run_mix(250, 65, 20);
    run_mix(230, 25, 60);
    calm <= 1'b1;
    run_mix(200, 45, 40);
    in_valid <= 1'b0;

    while (tracker.pending_status.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("ran %0d results through insert/delete/query on all lists and a bad selector",
             tracker.results_seen);
    $display("%0d inserts refused on full lists, %0d deletes of absent ids",
             tracker.full_refusals, tracker.absent_deletes);
    if (tracker.mismatches == 0 && tracker.pending_status.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
